// File: rtl/gfbl_pkg.sv
// Shared types and constants of the grouped free-block list unit.
package gfbl_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int GROUP_SIZE = 16;

    localparam int ID_W   = $clog2(NUM_BLOCKS);
    localparam int IDX_W  = $clog2(GROUP_SIZE);
    localparam int CNT_W  = $clog2(GROUP_SIZE + 1);
    localparam int WORD_W = GROUP_SIZE * ID_W + CNT_W;

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic {
        OP_FREE  = 1'b0,
        OP_ALLOC = 1'b1
    } t_op;

    typedef enum logic {
        ST_OK    = 1'b0,
        ST_EMPTY = 1'b1
    } t_status;

    typedef struct packed {
        t_op operation;
        t_id block_id;
    } t_req;

    typedef struct packed {
        t_status status;
        t_id     granted_block;
    } t_rsp;

endpackage

// File: rtl/gfbl_if.sv
// Valid/ready channel interfaces for requests and responses.
interface gfbl_req_if;
    import gfbl_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gfbl_rsp_if;
    import gfbl_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/gfbl_out_skid.sv
// Two-entry response buffer: output register plus skid register.
module gfbl_out_skid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gfbl_pkg::t_rsp i_data,
    output logic           o_full,
    gfbl_rsp_if.source     o_rsp
);
    import gfbl_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_rsp r_out_data;
    t_rsp r_skid_data;
    logic pop;

    assign pop         = r_out_valid && o_rsp.ready;
    assign o_full      = r_skid_valid;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

    // A push is only offered while the skid register is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_valid) begin
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= i_push;
                    if (i_push) begin
                        r_skid_data <= i_data;
                    end
                end else begin
                    r_out_valid <= i_push;
                    if (i_push) begin
                        r_out_data <= i_data;
                    end
                end
            end else if (!r_out_valid) begin
                r_out_valid <= i_push;
                if (i_push) begin
                    r_out_data <= i_data;
                end
            end else if (i_push) begin
                r_skid_data  <= i_data;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

// File: rtl/grouped_free_block_list_unit.sv
// Top level of the grouped free-block list allocator.
//
//  Channel  | Dir | Signals              | Transfer when
//  ---------+-----+----------------------+----------------------------
//  i_req    | in  | operation, block_id  | i_req.valid && i_req.ready
//  o_rsp    | out | status, granted_block| o_rsp.valid && o_rsp.ready
//
// A free, or an allocate that leaves at least one entry in the active stack,
// is taken in the same cycle as it is offered while the output buffer has room.
// An allocate that pops the last entry then holds off requests in S_RELOAD,
// waiting on the registered read of the group store that holds the next group.
// Reset (synchronous, active low) empties the stack down to the sentinel and
// clears all handshake state; the group store itself is not cleared.
// Responses queue in a two-entry buffer, so requests keep flowing while one
// response waits; requests stall once that buffer is full or during a reload.
module grouped_free_block_list_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gfbl_req_if.sink   i_req,
    gfbl_rsp_if.source o_rsp
);
    import gfbl_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RELOAD
    } t_state;

    t_state r_state;

    // The active stack: entry 0 is the bottom, r_count entries are valid.
    t_id  r_stack [GROUP_SIZE];
    t_cnt r_count;

    // Backing store: one word per block id, holding a saved group and length.
    t_word group_store [NUM_BLOCKS];
    t_word r_rd_data;

    logic  skid_full;
    logic  accept;
    logic  is_alloc;
    logic  is_empty;
    logic  do_spill;
    logic  do_reload;
    t_idx  top_idx;
    t_id   top_id;
    t_word spill_word;
    t_cnt  load_count;
    t_rsp  rsp;

    assign i_req.ready = (r_state == S_IDLE) && !skid_full;
    assign accept      = i_req.valid && i_req.ready;

    assign top_idx  = t_idx'(r_count - t_cnt'(1));
    assign top_id   = r_stack[top_idx];
    assign is_alloc = (i_req.data.operation == OP_ALLOC);
    assign is_empty = (top_id == '0);

    // A free onto a full stack saves the group into the freed block's slot;
    // an allocate of the last entry brings in the group saved in its slot.
    assign do_spill  = !is_alloc && (r_count == t_cnt'(GROUP_SIZE));
    assign do_reload = is_alloc && !is_empty && (r_count == t_cnt'(1));

    always_comb begin
        spill_word = '0;
        for (int i = 0; i < GROUP_SIZE; i++) begin
            spill_word[i*ID_W +: ID_W] = r_stack[i];
        end
        spill_word[WORD_W-1 -: CNT_W] = r_count;
    end

    // The saved length is clamped into the valid range when it is loaded.
    always_comb begin
        load_count = r_rd_data[WORD_W-1 -: CNT_W];
        if (load_count == '0) begin
            load_count = t_cnt'(1);
        end else if (load_count > t_cnt'(GROUP_SIZE)) begin
            load_count = t_cnt'(GROUP_SIZE);
        end
    end

    // The response is fully known when the request is taken, even for a
    // reload, so it is handed to the output buffer straight away.
    always_comb begin
        rsp.status        = (is_alloc && is_empty) ? ST_EMPTY : ST_OK;
        rsp.granted_block = (is_alloc && !is_empty) ? top_id : '0;
    end

    // Group store port. A write (spill) and a read (reload) always belong to
    // different requests, and the read is issued in a later cycle than any
    // earlier write, so the same entry never sees overlapping accesses.
    always_ff @(posedge i_clk) begin
        if (accept && do_spill) begin
            group_store[i_req.data.block_id] <= spill_word;
        end
        if (accept && do_reload) begin
            r_rd_data <= group_store[top_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= t_cnt'(1);
            for (int i = 0; i < GROUP_SIZE; i++) begin
                r_stack[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!is_alloc) begin
                            if (do_spill) begin
                                for (int i = 0; i < GROUP_SIZE; i++) begin
                                    r_stack[i] <= '0;
                                end
                                r_stack[0] <= i_req.data.block_id;
                                r_count    <= t_cnt'(1);
                            end else begin
                                r_stack[t_idx'(r_count)] <= i_req.data.block_id;
                                r_count <= r_count + t_cnt'(1);
                            end
                        end else if (!is_empty) begin
                            if (do_reload) begin
                                r_state <= S_RELOAD;
                            end else begin
                                r_count <= r_count - t_cnt'(1);
                            end
                        end
                    end
                end
                S_RELOAD: begin
                    for (int i = 0; i < GROUP_SIZE; i++) begin
                        r_stack[i] <= r_rd_data[i*ID_W +: ID_W];
                    end
                    r_count <= load_count;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    gfbl_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (rsp),
        .o_full  (skid_full),
        .o_rsp   (o_rsp)
    );

endmodule
